[rtl/lirs_pkg.sv]
// ----------------------------------------------------------------------------
// lirs_pkg
// Types, constants and helpers shared by the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

    // Datapath sizes
    localparam int LANES           = 2;
    localparam int SAMPLE_BITS     = 24;
    localparam int PHASE_FRAC_BITS = 24;
    localparam int PHASE_BITS      = PHASE_FRAC_BITS + 9;
    localparam int STEP_BITS       = 32;
    localparam int CC_BITS         = 2;
    localparam int MAX_OUT         = 64;
    localparam int CNT_BITS        = $clog2(MAX_OUT);
    localparam int ADDR_BITS       = 4;
    localparam int DATA_BITS       = 32;

    // Phase value of one source frame interval
    localparam logic [PHASE_BITS-1:0] PHASE_ONE =
        {{(PHASE_BITS-PHASE_FRAC_BITS-1){1'b0}}, 1'b1, {PHASE_FRAC_BITS{1'b0}}};
    localparam logic [PHASE_BITS-1:0] PHASE_MAX = {PHASE_BITS{1'b1}};

    // Register values after reset
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(PHASE_ONE);
    localparam logic [CC_BITS-1:0]   CC_RESET   = CC_BITS'(2);

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PHASE_STEP    = 2'd0;
    localparam logic [1:0] REG_BYPASS        = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    // Input item commands
    localparam logic CMD_FRAME   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Operations passed from the front to the back
    localparam logic [2:0] OP_RESTART     = 3'd0;
    localparam logic [2:0] OP_BYPASS      = 3'd1;
    localparam logic [2:0] OP_LOAD_FIRST  = 3'd2;
    localparam logic [2:0] OP_LOAD_SINGLE = 3'd3;
    localparam logic [2:0] OP_LOAD_SECOND = 3'd4;
    localparam logic [2:0] OP_SHIFT       = 3'd5;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [LANES-1:0]    t_frame;

    typedef struct packed {
        logic    cmd;
        t_sample sample_0;
        t_sample sample_1;
        logic    final_frame;
    } t_in_item;

    typedef struct packed {
        t_sample out_0;
        t_sample out_1;
        logic    last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [STEP_BITS-1:0] phase_step;
        logic                 bypass;
        logic [CC_BITS-1:0]   channel_count;
    } t_cfg;

    typedef struct packed {
        logic [2:0] op;
        t_frame     frame;
    } t_cmd_entry;

    // Lanes that take part for a given channel count
    function automatic logic [LANES-1:0] lane_mask(input logic [CC_BITS-1:0] cc);
        int n;
        logic [LANES-1:0] m;
        n = int'(cc);
        if (n == 0) n = 1;
        if (n > LANES) n = LANES;
        for (int c = 0; c < LANES; c++) begin
            m[c] = (c < n);
        end
        return m;
    endfunction

endpackage

[rtl/lirs_front.sv]
// ----------------------------------------------------------------------------
// lirs_front
// Accepts input items, tracks how full the window is and turns each item
// into an operation for the back end.
// ----------------------------------------------------------------------------
module lirs_front import lirs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_item,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd_entry o_q_entry
);

    localparam logic [1:0] LD_EMPTY = 2'd0;
    localparam logic [1:0] LD_ONE   = 2'd1;
    localparam logic [1:0] LD_FULL  = 2'd2;

    logic [1:0] r_loaded;
    logic [1:0] n_loaded;
    logic       accept;

    assign full     = i_q_full;
    assign accept   = push && !i_q_full;
    assign o_q_push = accept;

    // Classify the item against the window fill state
    always_comb begin
        n_loaded        = r_loaded;
        o_q_entry.frame = '0;
        o_q_entry.frame[0] = i_item.sample_0;
        if (LANES > 1) begin
            o_q_entry.frame[LANES > 1 ? 1 : 0] = i_item.sample_1;
        end
        o_q_entry.op = OP_SHIFT;
        priority if (i_item.cmd == CMD_RESTART) begin
            o_q_entry.op = OP_RESTART;
            n_loaded     = LD_EMPTY;
        end else if (i_cfg.bypass) begin
            o_q_entry.op = OP_BYPASS;
        end else if (r_loaded == LD_EMPTY) begin
            o_q_entry.op = i_item.final_frame ? OP_LOAD_SINGLE : OP_LOAD_FIRST;
            n_loaded     = i_item.final_frame ? LD_FULL : LD_ONE;
        end else if (r_loaded == LD_ONE) begin
            o_q_entry.op = OP_LOAD_SECOND;
            n_loaded     = LD_FULL;
        end else begin
            o_q_entry.op = OP_SHIFT;
        end
    end

    // Advance the fill state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= LD_EMPTY;
        end else if (accept) begin
            r_loaded <= n_loaded;
        end
    end

endmodule

[rtl/lirs_cmdq.sv]
// ----------------------------------------------------------------------------
// lirs_cmdq
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module lirs_cmdq import lirs_pkg::*; #(
    parameter int QDEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd_entry i_entry,
    output logic       o_full,
    input  logic       i_pop,
    output t_cmd_entry o_entry,
    output logic       o_empty
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd_entry      r_mem [QDEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(QDEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(QDEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[rtl/lirs_back.sv]
// ----------------------------------------------------------------------------
// lirs_back
// Holds the two-frame window and the phase, and runs the interpolation:
// one output item per cycle while the phase stays below one and the output is not stalled.
// ----------------------------------------------------------------------------
module lirs_back import lirs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_empty,
    input  t_cmd_entry i_q_entry,
    output logic       o_q_pop,
    output t_out_item  o_result,
    output logic       empty,
    input  logic       pop
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = DW + PHASE_FRAC_BITS + 1;

    logic                  r_state;
    logic                  n_state;
    t_frame                r_prev;
    t_frame                n_prev;
    t_frame                r_cur;
    t_frame                n_cur;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   n_count;
    t_out_item             r_out;
    t_out_item             n_out;
    logic                  r_out_valid;
    logic                  n_out_valid;

    logic [LANES-1:0]      mask;
    logic                  out_free;
    logic [PHASE_BITS:0]   phase_sum;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  run_last;
    t_frame                interp;
    logic signed [DW-1:0]  diff   [LANES];
    logic signed [PW-1:0]  prod   [LANES];
    logic signed [PW-1:0]  scaled [LANES];

    assign mask     = lane_mask(i_cfg.channel_count);
    assign out_free = !r_out_valid || pop;
    assign empty    = !r_out_valid;
    assign o_result = r_out;

    // Interpolate each lane: prev + floor((cur - prev) * frac)
    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            diff[c]   = $signed({r_cur[c][SAMPLE_BITS-1], r_cur[c]})
                      - $signed({r_prev[c][SAMPLE_BITS-1], r_prev[c]});
            prod[c]   = PW'(diff[c])
                      * PW'($signed({1'b0, r_phase[PHASE_FRAC_BITS-1:0]}));
            scaled[c] = prod[c] >>> PHASE_FRAC_BITS;
            interp[c] = r_prev[c] + scaled[c][SAMPLE_BITS-1:0];
        end
    end

    // Saturating phase advance and end-of-run detect
    assign phase_sum  = {1'b0, r_phase} + (PHASE_BITS+1)'(i_cfg.phase_step);
    assign phase_next = phase_sum[PHASE_BITS] ? PHASE_MAX : phase_sum[PHASE_BITS-1:0];
    assign run_last   = (phase_next >= PHASE_ONE) || (r_count == CNT_BITS'(MAX_OUT - 1));

    // Sequence window updates and output runs
    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_phase     = r_phase;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        o_q_pop     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_q_pop = 1'b1;
                    n_count = '0;
                    unique case (i_q_entry.op)
                        OP_RESTART: begin
                            n_prev  = '0;
                            n_cur   = '0;
                            n_phase = '0;
                        end
                        OP_BYPASS: begin
                            n_out.out_0       = mask[0] ? i_q_entry.frame[0] : '0;
                            n_out.out_1       = (LANES > 1 && mask[LANES-1])
                                              ? i_q_entry.frame[LANES-1] : '0;
                            n_out.last_of_run = 1'b1;
                            n_out_valid       = 1'b1;
                        end
                        OP_LOAD_FIRST: begin
                            for (int c = 0; c < LANES; c++) begin
                                if (mask[c]) n_prev[c] = i_q_entry.frame[c];
                            end
                        end
                        OP_LOAD_SINGLE: begin
                            for (int c = 0; c < LANES; c++) begin
                                if (mask[c]) begin
                                    n_prev[c] = i_q_entry.frame[c];
                                    n_cur[c]  = i_q_entry.frame[c];
                                end
                            end
                            n_phase = '0;
                            n_state = ST_EMIT;
                        end
                        OP_LOAD_SECOND: begin
                            for (int c = 0; c < LANES; c++) begin
                                if (mask[c]) n_cur[c] = i_q_entry.frame[c];
                            end
                            n_phase = '0;
                            n_state = ST_EMIT;
                        end
                        OP_SHIFT: begin
                            for (int c = 0; c < LANES; c++) begin
                                if (mask[c]) begin
                                    n_prev[c] = r_cur[c];
                                    n_cur[c]  = i_q_entry.frame[c];
                                end
                            end
                            if (r_phase >= PHASE_ONE) n_phase = r_phase - PHASE_ONE;
                            n_state = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (r_phase >= PHASE_ONE) begin
                    // downsampling: this frame yields nothing
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out.out_0       = mask[0] ? interp[0] : '0;
                    n_out.out_1       = (LANES > 1 && mask[LANES-1]) ? interp[LANES-1] : '0;
                    n_out.last_of_run = run_last;
                    n_out_valid       = 1'b1;
                    n_phase           = phase_next;
                    n_count           = r_count + CNT_BITS'(1);
                    if (run_last) n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Advance control state and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev      <= '0;
            r_cur       <= '0;
            r_phase     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_cur       <= n_cur;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/linear_interp_resampler_unit.sv]
// An accepted source frame is queued; the back end pops it, loads the window, then
// registers its first output item (a bypassed frame's item is registered as it is popped).
// Throughput: one output item per cycle while the output is not stalled, within a run of
// up to 64 items, plus a window load per source frame (and an empty emit state when it
// yields none). Input accepts at one item per cycle until the operation queue fills.
// Reset (synchronous, active low) clears window, phase, queue and registers to defaults.
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Linear interpolation sample rate converter with a configuration port.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit import lirs_pkg::*; #(
    parameter int QDEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_item,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic       q_push;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    t_cmd_entry q_wr_entry;
    t_cmd_entry q_rd_entry;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step    <= STEP_RESET;
            r_cfg.bypass        <= 1'b0;
            r_cfg.channel_count <= CC_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PHASE_STEP:    r_cfg.phase_step    <= pwdata[STEP_BITS-1:0];
                REG_BYPASS:        r_cfg.bypass        <= pwdata[0];
                REG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[CC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (reg_idx)
            REG_PHASE_STEP:    prdata = DATA_BITS'(r_cfg.phase_step);
            REG_BYPASS:        prdata = DATA_BITS'(r_cfg.bypass);
            REG_CHANNEL_COUNT: prdata = DATA_BITS'(r_cfg.channel_count);
            default:           prdata = '0;
        endcase
    end

    lirs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_entry (q_wr_entry)
    );

    lirs_cmdq #(
        .QDEPTH (QDEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry),
        .o_empty (q_empty)
    );

    lirs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_entry (q_rd_entry),
        .o_q_pop   (q_pop),
        .o_result  (o_result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

[rtl/lirs_checker.sv]
// ----------------------------------------------------------------------------
// lirs_checker
// Port-level checks for the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module lirs_checker import lirs_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 push,
    input logic                 full,
    input t_in_item             i_item,
    input logic                 empty,
    input logic                 pop,
    input t_out_item            o_result,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [ADDR_BITS-1:0] paddr,
    input logic [DATA_BITS-1:0] pwdata,
    input logic [DATA_BITS-1:0] prdata,
    input logic                 pready
);

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset followed by no push leaves no result
    a_no_spurious: assert property (@(posedge i_clk)
        (!i_rst_n ##1 !push) |=> empty)
        else $error("result shown with no item accepted");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

    // Narrow registers read back with zero upper bits
    a_narrow_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && !pwrite && (paddr[3:2] == REG_BYPASS || paddr[3:2] == REG_CHANNEL_COUNT))
        |-> (prdata[DATA_BITS-1:CC_BITS] == '0))
        else $error("configuration read has stray upper bits");

endmodule

bind linear_interp_resampler_unit lirs_checker u_lirs_checker (.*);
